// ----- rtl/cfd_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants shared by the checksum frame deframer.
package cfd_pkg;

    // Receive phase, one-hot coded.
    typedef enum logic [2:0] {
        PH_HUNT   = 3'b001,
        PH_HEADER = 3'b010,
        PH_DATA   = 3'b100
    } t_phase;

    // Status codes carried by a result word.
    localparam logic [2:0] ST_PAYLOAD  = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_HDR_ERR  = 3'd2;
    localparam logic [2:0] ST_DATA_ERR = 3'd3;
    localparam logic [2:0] ST_SHORT    = 3'd4;

    // Configuration register indexes (word address).
    localparam logic REG_SYNC_WORD = 1'b0;

    localparam logic [31:0] SYNC_RESET   = 32'hD0F9_EE5D;
    localparam int          HEADER_BYTES = 8;
    localparam logic [15:0] LEN_OVERHEAD = 16'd4;

    // One result word.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] command;
        logic [15:0] payload_length;
        logic        has_byte;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic        last;
    } t_result;

endpackage

// ----- rtl/checksum_frame_deframer_top.sv -----
`timescale 1ns / 1ps
// Top level of the checksum frame deframer: sync hunt, header check, payload forwarding.
//
//  Channel   Direction  Handshake                     Payload
//  -------   ---------  ----------------------------  ---------------------------------
//  in        input      i_in_valid / o_in_ready       i_rx_byte
//  out       output     o_out_valid / i_out_ready     o_status .. o_last (seven fields)
//  config    input      psel, penable, pwrite, pready paddr, pwdata, prdata (sync_word)
//
// One received word is taken per cycle while the skid register is empty. All
// of its work is a single pass of logic between the state registers and the
// result register; a result goes to the skid register while the output stalls.
// Synchronous active-low reset puts the block in the hunting phase with an
// empty shift register, empty result stages, and sync_word at D0F9EE5D.
// A result register plus one skid register decouple the sides: input stays
// ready while a result waits, and drops ready only when the skid register
// is also full, so a stall on the output costs at most one held word.
module checksum_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Received byte stream.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    // Result stream.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_command,
    output logic [15:0] o_payload_length,
    output logic        o_has_byte,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_byte_index,
    output logic        o_last,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    cfd_pkg::t_phase  r_phase, n_phase;
    logic [31:0]      r_sync_word;
    logic [31:0]      r_hunt_shift, n_hunt_shift;
    logic [15:0]      r_byte_count, n_byte_count;
    logic [15:0]      r_payload_sum, n_payload_sum;
    logic [7:0]       r_hdr [cfd_pkg::HEADER_BYTES];

    cfd_pkg::t_result r_out, n_out;
    cfd_pkg::t_result r_skid, n_skid;
    logic             r_out_valid, n_out_valid;
    logic             r_skid_valid, n_skid_valid;

    logic             in_fire;
    logic             out_fire;
    logic             cfg_write;

    cfd_pkg::t_result res;
    logic             res_valid;

    logic [15:0]      hdr_command;
    logic [15:0]      hdr_msg_len;
    logic [15:0]      hdr_plen;
    logic [15:0]      hdr_sum;
    logic [15:0]      count_inc;

    assign in_fire   = i_in_valid && o_in_ready;
    assign out_fire  = r_out_valid && i_out_ready;
    assign cfg_write = psel && penable && pwrite && pready;

    // The configuration port never stalls; reads with paddr[2] clear return the sync word, other reads zero.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == cfd_pkg::REG_SYNC_WORD) ? r_sync_word : 32'd0;

    // Input is refused only while the skid register holds a word.
    assign o_in_ready = !r_skid_valid;

    // Header fields as stored. The header checksum covers the sync word and bytes 0 to 3
    // and sits in bytes 4 and 5, all of which are stored before the eighth header byte arrives.
    assign hdr_command = {r_hdr[0], r_hdr[1]};
    assign hdr_msg_len = {r_hdr[2], r_hdr[3]};
    assign hdr_plen    = hdr_msg_len - cfd_pkg::LEN_OVERHEAD;
    assign hdr_sum     = 16'(r_sync_word[31:24]) + 16'(r_sync_word[23:16])
                       + 16'(r_sync_word[15:8])  + 16'(r_sync_word[7:0])
                       + 16'(r_hdr[0]) + 16'(r_hdr[1])
                       + 16'(r_hdr[2]) + 16'(r_hdr[3]);
    assign count_inc   = r_byte_count + 16'd1;

    // ------------------------------------------------------------------
    // Frame state update and result formation for one accepted word
    // ------------------------------------------------------------------
    always_comb begin
        n_phase       = r_phase;
        n_hunt_shift  = r_hunt_shift;
        n_byte_count  = r_byte_count;
        n_payload_sum = r_payload_sum;
        res_valid     = 1'b0;
        res           = '0;

        if (in_fire) begin
            case (r_phase)
                cfd_pkg::PH_HEADER: begin
                    n_byte_count = count_inc;
                    if (count_inc >= 16'(cfd_pkg::HEADER_BYTES)) begin
                        res_valid   = 1'b1;
                        res.command = hdr_command;
                        res.last    = 1'b1;
                        if (hdr_sum != {r_hdr[4], r_hdr[5]}) begin
                            res.status   = cfd_pkg::ST_HDR_ERR;
                            n_phase      = cfd_pkg::PH_HUNT;
                            n_hunt_shift = '0;
                        end else if (hdr_msg_len < cfd_pkg::LEN_OVERHEAD) begin
                            res.status   = cfd_pkg::ST_SHORT;
                            n_phase      = cfd_pkg::PH_HUNT;
                            n_hunt_shift = '0;
                        end else if (hdr_plen == 16'd0) begin
                            // Empty payload: the frame is complete right here.
                            res.status   = cfd_pkg::ST_OK;
                            n_phase      = cfd_pkg::PH_HUNT;
                            n_hunt_shift = '0;
                        end else begin
                            res_valid     = 1'b0;
                            n_phase       = cfd_pkg::PH_DATA;
                            n_byte_count  = '0;
                            n_payload_sum = '0;
                        end
                    end
                end
                cfd_pkg::PH_DATA: begin
                    n_payload_sum      = r_payload_sum + 16'(i_rx_byte);
                    n_byte_count       = count_inc;
                    res_valid          = 1'b1;
                    res.command        = hdr_command;
                    res.payload_length = hdr_plen;
                    res.has_byte       = 1'b1;
                    res.data_byte      = i_rx_byte;
                    res.byte_index     = r_byte_count;
                    if (count_inc < hdr_plen) begin
                        res.status = cfd_pkg::ST_PAYLOAD;
                    end else begin
                        res.last     = 1'b1;
                        res.status   = (n_payload_sum == {r_hdr[6], r_hdr[7]})
                                     ? cfd_pkg::ST_OK : cfd_pkg::ST_DATA_ERR;
                        n_phase      = cfd_pkg::PH_HUNT;
                        n_hunt_shift = '0;
                    end
                end
                default: begin
                    // Hunting, and any code outside the three phases.
                    n_phase      = cfd_pkg::PH_HUNT;
                    n_hunt_shift = {r_hunt_shift[23:0], i_rx_byte};
                    if (n_hunt_shift == r_sync_word) begin
                        n_phase      = cfd_pkg::PH_HEADER;
                        n_byte_count = '0;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result register and skid register
    // ------------------------------------------------------------------
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = res;
                n_out_valid = res_valid;
            end
        end else if (res_valid) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= cfd_pkg::PH_HUNT;
            r_sync_word   <= cfd_pkg::SYNC_RESET;
            r_hunt_shift  <= '0;
            r_byte_count  <= '0;
            r_payload_sum <= '0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_hunt_shift  <= n_hunt_shift;
            r_byte_count  <= n_byte_count;
            r_payload_sum <= n_payload_sum;
            r_out_valid   <= n_out_valid;
            r_skid_valid  <= n_skid_valid;
            if (cfg_write && paddr[2] == cfd_pkg::REG_SYNC_WORD) begin
                r_sync_word <= pwdata;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
        if (in_fire && r_phase == cfd_pkg::PH_HEADER) begin
            r_hdr[r_byte_count[2:0]] <= i_rx_byte;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_command        = r_out.command;
    assign o_payload_length = r_out.payload_length;
    assign o_has_byte       = r_out.has_byte;
    assign o_data_byte      = r_out.data_byte;
    assign o_byte_index     = r_out.byte_index;
    assign o_last           = r_out.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The skid register is only filled behind a held result word.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty result register");

    // A new result arriving behind a stalled result is parked, not dropped.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && r_out_valid && !i_out_ready) |=> r_skid_valid)
        else $error("result dropped while output stalled");

    // A result without a payload byte always closes its frame.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_byte) |-> o_last)
        else $error("result without byte not marked last");

    // Mid-frame payload words are never marked last.
    a_payload_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == cfd_pkg::ST_PAYLOAD) |-> (o_has_byte && !o_last))
        else $error("payload word with bad flags");

endmodule

// ----- dv/checksum_frame_deframer_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the checksum frame deframer: frames in, result words checked.
module checksum_frame_deframer_top_test;

    localparam logic [2:0] SYNC_ADDR = {cfd_pkg::REG_SYNC_WORD, 2'b00};

    // Shapes of frame that the stimulus can build.
    typedef enum {FR_GOOD, FR_DATA_BAD, FR_HDR_BAD} t_frame_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_command;
    logic [15:0] o_payload_length;
    logic        o_has_byte;
    logic [7:0]  o_data_byte;
    logic [15:0] o_byte_index;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    checksum_frame_deframer_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_command        (o_command),
        .o_payload_length (o_payload_length),
        .o_has_byte       (o_has_byte),
        .o_data_byte      (o_data_byte),
        .o_byte_index     (o_byte_index),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 0;
    end

    // Bytes waiting to be sent and result words waiting to be seen.
    logic [7:0]       rx_stream[$];
    cfd_pkg::t_result results_due[$];
    int unsigned      mismatch_count = 0;
    int unsigned      in_gap_pct = 18;
    int unsigned      out_stall_pct = 68;
    bit               byte_taken = 1'b0;

    // Deframer state as the testbench sees it.
    logic [31:0]     mdl_sync = cfd_pkg::SYNC_RESET;
    logic [31:0]     mdl_shift = '0;
    cfd_pkg::t_phase mdl_phase = cfd_pkg::PH_HUNT;
    logic [15:0]     mdl_count = '0;
    logic [7:0]      mdl_header[cfd_pkg::HEADER_BYTES];
    logic [15:0]     mdl_sum = '0;

    function automatic void report_fail(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endfunction

    function automatic string result_text(input cfd_pkg::t_result r);
        return $sformatf("status=%0d cmd=%h plen=%h has=%b byte=%h idx=%h last=%b",
                         r.status, r.command, r.payload_length, r.has_byte,
                         r.data_byte, r.byte_index, r.last);
    endfunction

    // Advances the deframer state by one received byte and returns the
    // result word it causes, if any.
    function automatic void deframe_byte(input logic [7:0] rx, output bit made,
                                         output cfd_pkg::t_result res);
        logic [15:0] cmd;
        logic [15:0] mlen;
        logic [15:0] plen;
        logic [15:0] hsum;
        logic [15:0] idx;
        made = 1'b0;
        res = '0;
        cmd = {mdl_header[0], mdl_header[1]};
        mlen = {mdl_header[2], mdl_header[3]};
        plen = mlen - cfd_pkg::LEN_OVERHEAD;
        case (mdl_phase)
            cfd_pkg::PH_HEADER: begin
                mdl_header[mdl_count[2:0]] = rx;
                mdl_count = mdl_count + 16'd1;
                if (mdl_count >= cfd_pkg::HEADER_BYTES) begin
                    cmd = {mdl_header[0], mdl_header[1]};
                    mlen = {mdl_header[2], mdl_header[3]};
                    plen = mlen - cfd_pkg::LEN_OVERHEAD;
                    // The header sum uses the sync word as it stands right now.
                    hsum = mdl_sync[31:24] + mdl_sync[23:16] + mdl_sync[15:8]
                         + mdl_sync[7:0] + mdl_header[0] + mdl_header[1]
                         + mdl_header[2] + mdl_header[3];
                    made = 1'b1;
                    res.command = cmd;
                    res.last = 1'b1;
                    if (hsum != {mdl_header[4], mdl_header[5]}) begin
                        res.status = cfd_pkg::ST_HDR_ERR;
                    end else if (mlen < cfd_pkg::LEN_OVERHEAD) begin
                        res.status = cfd_pkg::ST_SHORT;
                    end else if (plen == 16'd0) begin
                        res.status = cfd_pkg::ST_OK;
                    end else begin
                        made = 1'b0;
                        mdl_phase = cfd_pkg::PH_DATA;
                        mdl_count = '0;
                        mdl_sum = '0;
                    end
                    if (made) begin
                        mdl_phase = cfd_pkg::PH_HUNT;
                        mdl_shift = '0;
                    end
                end
            end
            cfd_pkg::PH_DATA: begin
                idx = mdl_count;
                mdl_sum = mdl_sum + rx;
                mdl_count = mdl_count + 16'd1;
                made = 1'b1;
                res.command = cmd;
                res.payload_length = plen;
                res.has_byte = 1'b1;
                res.data_byte = rx;
                res.byte_index = idx;
                if (mdl_count < plen) begin
                    res.status = cfd_pkg::ST_PAYLOAD;
                end else begin
                    res.last = 1'b1;
                    res.status = (mdl_sum == {mdl_header[6], mdl_header[7]})
                               ? cfd_pkg::ST_OK : cfd_pkg::ST_DATA_ERR;
                    mdl_phase = cfd_pkg::PH_HUNT;
                    mdl_shift = '0;
                end
            end
            default: begin
                mdl_phase = cfd_pkg::PH_HUNT;
                mdl_shift = {mdl_shift[23:0], rx};
                if (mdl_shift == mdl_sync) begin
                    mdl_phase = cfd_pkg::PH_HEADER;
                    mdl_count = '0;
                end
            end
        endcase
    endfunction

    // With an all-zero sync word a single zero byte starts a header, since
    // the shift register is clear whenever hunting resumes.
    function automatic void push_lead(ref logic [7:0] q[$], input logic [31:0] sync);
        if (sync == 32'd0) begin
            q.push_back(8'h00);
        end else begin
            q.push_back(sync[31:24]);
            q.push_back(sync[23:16]);
            q.push_back(sync[15:8]);
            q.push_back(sync[7:0]);
        end
    endfunction

    // Appends one frame. The lead and the header sum may use different sync
    // words, so that the register can change while the header is collected.
    function automatic void build_frame(ref logic [7:0] q[$], input t_frame_kind kind,
                                        input logic [31:0] lead_sync,
                                        input logic [31:0] sum_sync,
                                        input logic [15:0] cmd, input logic [15:0] msg_len,
                                        input bit extreme_fill);
        logic [15:0] hsum;
        logic [15:0] dsum;
        logic [7:0]  pay[$];
        logic [7:0]  b;
        int unsigned n;
        hsum = sum_sync[31:24] + sum_sync[23:16] + sum_sync[15:8] + sum_sync[7:0]
             + cmd[15:8] + cmd[7:0] + msg_len[15:8] + msg_len[7:0];
        dsum = '0;
        n = (kind != FR_HDR_BAD && msg_len > cfd_pkg::LEN_OVERHEAD)
          ? msg_len - cfd_pkg::LEN_OVERHEAD : 0;
        for (int i = 0; i < n; i++) begin
            b = extreme_fill ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom);
            pay.push_back(b);
            dsum = dsum + b;
        end
        if (kind == FR_HDR_BAD) begin
            hsum = hsum ^ 16'($urandom_range(1, 65535));
        end
        if (kind == FR_DATA_BAD) begin
            dsum = dsum ^ 16'($urandom_range(1, 65535));
        end
        push_lead(q, lead_sync);
        q.push_back(cmd[15:8]);
        q.push_back(cmd[7:0]);
        q.push_back(msg_len[15:8]);
        q.push_back(msg_len[7:0]);
        q.push_back(hsum[15:8]);
        q.push_back(hsum[7:0]);
        q.push_back(dsum[15:8]);
        q.push_back(dsum[7:0]);
        foreach (pay[i]) q.push_back(pay[i]);
    endfunction

    // Mostly well-formed frames of every outcome; with noise allowed, some
    // stray bytes and headers cut short as well. Ends on a clean frame so
    // that the next phase starts from hunting.
    task automatic queue_random_traffic(input logic [31:0] sync, input int unsigned budget,
                                        input bit allow_noise);
        int unsigned start;
        int unsigned pick;
        start = rx_stream.size();
        while (rx_stream.size() - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                build_frame(rx_stream, FR_GOOD, sync, sync, 16'($urandom),
                            16'(4 + $urandom_range(1, 12)), 1'b0);
            end else if (pick < 68) begin
                build_frame(rx_stream, FR_DATA_BAD, sync, sync, 16'($urandom),
                            16'(4 + $urandom_range(1, 12)), 1'b0);
            end else if (pick < 78) begin
                build_frame(rx_stream, FR_HDR_BAD, sync, sync, 16'($urandom),
                            16'($urandom), 1'b0);
            end else if (pick < 86) begin
                build_frame(rx_stream, FR_GOOD, sync, sync, 16'($urandom),
                            16'($urandom_range(0, 3)), 1'b0);
            end else if (pick < 92 || !allow_noise) begin
                build_frame(rx_stream, FR_GOOD, sync, sync, 16'($urandom),
                            cfd_pkg::LEN_OVERHEAD, 1'b0);
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    push_lead(rx_stream, sync);
                end
                repeat ($urandom_range(1, 7)) rx_stream.push_back(8'($urandom));
            end
        end
        build_frame(rx_stream, FR_GOOD, sync, sync, 16'($urandom), 16'd7, 1'b0);
    endtask

    // Waits until every byte is taken and every result word has come, then
    // lets the clock run on for a byte that produced no result.
    task automatic wait_idle();
        while (rx_stream.size() != 0 || i_in_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the sync word and reads it back.
    task automatic write_sync(input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SYNC_ADDR;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            report_fail($sformatf("sync word read back %h, wrote %h", prdata, value));
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sender: a new word goes out only once the previous one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || byte_taken) begin
                if (rx_stream.size() != 0 && $urandom_range(0, 99) >= in_gap_pct) begin
                    i_in_valid <= 1'b1;
                    i_rx_byte <= rx_stream.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    // Monitor: checks each result word against the oldest one due, then
    // predicts from the byte taken at this edge and tracks register writes.
    always @(posedge i_clk) begin : monitor
        cfd_pkg::t_result got;
        cfd_pkg::t_result want;
        bit               made;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.status = o_status;
                got.command = o_command;
                got.payload_length = o_payload_length;
                got.has_byte = o_has_byte;
                got.data_byte = o_data_byte;
                got.byte_index = o_byte_index;
                got.last = o_last;
                if (results_due.size() == 0) begin
                    report_fail({"unexpected result: ", result_text(got)});
                end else begin
                    want = results_due.pop_front();
                    if (got.status !== want.status || got.command !== want.command
                        || got.payload_length !== want.payload_length
                        || got.has_byte !== want.has_byte
                        || got.data_byte !== want.data_byte
                        || got.byte_index !== want.byte_index
                        || got.last !== want.last) begin
                        report_fail({"expected ", result_text(want), " got ",
                                     result_text(got)});
                    end
                end
            end
            byte_taken = i_in_valid && o_in_ready;
            if (byte_taken) begin
                deframe_byte(i_rx_byte, made, want);
                if (made) results_due.push_back(want);
            end
            if (psel && penable && pwrite && pready && paddr == SYNC_ADDR) begin
                mdl_sync = pwdata;
            end
        end
    end

    logic [7:0]  split_frame[$];
    logic [31:0] cur_sync;
    logic [31:0] next_sync;

    initial begin : stimulus
        foreach (mdl_header[i]) mdl_header[i] = '0;
        cur_sync = cfd_pkg::SYNC_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset sync word: extreme commands and
        // payload bytes, a data sum error, a header sum error with the
        // largest length, the short lengths, an empty payload, and stray
        // bytes of all zeros and all ones ahead of a frame.
        build_frame(rx_stream, FR_GOOD, cur_sync, cur_sync, 16'hFFFF, 16'd7, 1'b1);
        build_frame(rx_stream, FR_DATA_BAD, cur_sync, cur_sync, 16'h0000, 16'd6, 1'b1);
        build_frame(rx_stream, FR_HDR_BAD, cur_sync, cur_sync, 16'($urandom), 16'hFFFF,
                    1'b0);
        build_frame(rx_stream, FR_GOOD, cur_sync, cur_sync, 16'($urandom), 16'd0, 1'b0);
        build_frame(rx_stream, FR_GOOD, cur_sync, cur_sync, 16'($urandom), 16'd3, 1'b0);
        build_frame(rx_stream, FR_GOOD, cur_sync, cur_sync, 16'h1234,
                    cfd_pkg::LEN_OVERHEAD, 1'b0);
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        build_frame(rx_stream, FR_GOOD, cur_sync, cur_sync, 16'($urandom), 16'd5, 1'b0);
        wait_idle();

        // The sync word changes while a header is partly collected; the header
        // sum must follow the new value.
        do next_sync = $urandom(); while (next_sync == cur_sync || next_sync == 32'd0);
        build_frame(split_frame, FR_GOOD, cur_sync, next_sync, 16'($urandom), 16'd6, 1'b0);
        repeat (7) rx_stream.push_back(split_frame.pop_front());
        wait_idle();
        write_sync(next_sync);
        cur_sync = next_sync;
        while (split_frame.size() != 0) rx_stream.push_back(split_frame.pop_front());
        queue_random_traffic(cur_sync, 60, 1'b1);
        wait_idle();

        // All-zero sync word, with the idle pattern swapped.
        in_gap_pct = 68;
        out_stall_pct = 18;
        cur_sync = 32'h0000_0000;
        write_sync(cur_sync);
        queue_random_traffic(cur_sync, 40, 1'b0);
        wait_idle();

        // All-ones sync word at full rate, with one long payload.
        in_gap_pct = 0;
        out_stall_pct = 0;
        cur_sync = 32'hFFFF_FFFF;
        write_sync(cur_sync);
        queue_random_traffic(cur_sync, 20, 1'b1);
        build_frame(rx_stream, FR_GOOD, cur_sync, cur_sync, 16'($urandom), 16'd261, 1'b0);
        wait_idle();
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
